// ===== rtl/tfag_pkg.sv =====
// shared types, constants and helpers of the tensor flip address generator
package tfag_pkg;

  localparam int MaxRank  = 4;
  localparam int DimBits  = 8;
  localparam int SizeW    = DimBits + 1;
  localparam int AddrW    = 32;
  localparam int DataW    = 32;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = SizeW;
  localparam int RankW    = (MaxRank > 1) ? $clog2(MaxRank) : 1;

  typedef logic [DimBits-1:0] coord_t;
  typedef logic [SizeW-1:0]   size_t;
  typedef logic [AddrW-1:0]   stride_t;
  typedef logic [DataW-1:0]   data_t;

  // register map: the size registers sit at indexes 0 to 3, then the flip mask
  localparam logic [CfgIdxW-1:0] RegSizeDim0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFlipMask = 3'd4;

  localparam size_t SizeLimit = size_t'(1) << DimBits;

  // effective sizes and strides handed from the register block to the datapath
  typedef struct packed {
    size_t   [MaxRank-1:0] size;
    logic    [MaxRank-1:0] flip;
    stride_t [MaxRank-1:0] stride;
    logic                  busy;
  } cfg_t;

  // a zero size acts as one, anything above the limit is clamped to it
  function automatic size_t eff_size(input size_t s);
    size_t r;
    if (s == '0) begin
      r = size_t'(1);
    end else if (s > SizeLimit) begin
      r = SizeLimit;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

// ===== rtl/tfag_cfg_regs.sv =====
// configuration registers and the stride sequencer
module tfag_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [tfag_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tfag_pkg::CfgDataW-1:0]   cfg_data_i,
  output tfag_pkg::cfg_t                  cfg_o
);

  tfag_pkg::size_t   size_q   [tfag_pkg::MaxRank];
  logic [tfag_pkg::MaxRank-1:0] flip_q;
  tfag_pkg::stride_t stride_q [tfag_pkg::MaxRank];
  logic                         busy_q;
  logic [tfag_pkg::RankW-1:0]   dim_q;
  logic [tfag_pkg::RankW-1:0]   dim_nxt;
  tfag_pkg::stride_t            prod;

  // one stride per cycle while no new write arrives, from the inner dimensions outward
  assign dim_nxt = dim_q + tfag_pkg::RankW'(1);
  assign prod    = stride_q[dim_nxt]
                 * tfag_pkg::AddrW'(tfag_pkg::eff_size(size_q[dim_nxt]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < tfag_pkg::MaxRank; k++) begin
        size_q[k]   <= tfag_pkg::size_t'(1);
        stride_q[k] <= tfag_pkg::stride_t'(1);
      end
      flip_q <= '0;
      busy_q <= 1'b0;
      dim_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i < tfag_pkg::RegFlipMask) begin
          if (cfg_index_i - tfag_pkg::RegSizeDim0 < tfag_pkg::CfgIdxW'(tfag_pkg::MaxRank)) begin
            size_q[cfg_index_i[tfag_pkg::RankW-1:0]] <= cfg_data_i[tfag_pkg::SizeW-1:0];
          end
        end else if (cfg_index_i == tfag_pkg::RegFlipMask) begin
          flip_q <= cfg_data_i[tfag_pkg::MaxRank-1:0];
        end
        busy_q <= (tfag_pkg::MaxRank > 1);
        dim_q  <= tfag_pkg::RankW'(tfag_pkg::MaxRank - 2);
      end else if (busy_q) begin
        stride_q[dim_q] <= prod;
        if (dim_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          dim_q <= dim_q - tfag_pkg::RankW'(1);
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < tfag_pkg::MaxRank; k++) begin
      cfg_o.size[k]   = tfag_pkg::eff_size(size_q[k]);
      cfg_o.stride[k] = stride_q[k];
    end
    cfg_o.flip = flip_q;
    cfg_o.busy = busy_q;
  end

  // the innermost stride step must have used the current innermost size
  a_stride_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> stride_q[tfag_pkg::MaxRank-2]
      == tfag_pkg::AddrW'(tfag_pkg::eff_size(size_q[tfag_pkg::MaxRank-1])))
    else $error("stride sequencer finished with a stale inner stride");

  a_inner_stride_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stride_q[tfag_pkg::MaxRank-1] == tfag_pkg::stride_t'(1))
    else $error("innermost stride is not one");

endmodule

// ===== rtl/tfag_coord_ctr.sv =====
// per-dimension coordinate counters, clamping and mirroring
module tfag_coord_ctr (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     acc_i,
  input  tfag_pkg::cfg_t                           cfg_i,
  output tfag_pkg::coord_t [tfag_pkg::MaxRank-1:0] coord_o,
  output logic                                     last_o
);

  tfag_pkg::coord_t ctr_q [tfag_pkg::MaxRank];
  tfag_pkg::coord_t ctr_d [tfag_pkg::MaxRank];
  logic [tfag_pkg::MaxRank-1:0] at_end;

  always_comb begin
    tfag_pkg::size_t  sm1;
    tfag_pkg::coord_t lim;
    tfag_pkg::coord_t c;
    logic             carry;
    for (int k = 0; k < tfag_pkg::MaxRank; k++) begin
      sm1       = cfg_i.size[k] - tfag_pkg::size_t'(1);
      lim       = sm1[tfag_pkg::DimBits-1:0];
      at_end[k] = (ctr_q[k] >= lim);
      c         = at_end[k] ? lim : ctr_q[k];
      coord_o[k] = cfg_i.flip[k] ? (lim - c) : c;
    end
    // innermost first, carry outward while a dimension wraps
    carry = 1'b1;
    for (int k = tfag_pkg::MaxRank - 1; k >= 0; k--) begin
      ctr_d[k] = ctr_q[k];
      if (carry) begin
        ctr_d[k] = at_end[k] ? '0 : ctr_q[k] + tfag_pkg::coord_t'(1);
      end
      carry = carry & at_end[k];
    end
  end

  assign last_o = &at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < tfag_pkg::MaxRank; k++) begin
        ctr_q[k] <= '0;
      end
    end else if (acc_i) begin
      for (int k = 0; k < tfag_pkg::MaxRank; k++) begin
        ctr_q[k] <= ctr_d[k];
      end
    end
  end

  a_wrap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && last_o |=> ctr_q[0] == '0 && ctr_q[tfag_pkg::MaxRank-1] == '0)
    else $error("counters did not return to zero after the final element");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !last_o |=> ctr_q[tfag_pkg::MaxRank-1] != $past(ctr_q[tfag_pkg::MaxRank-1])
      || ctr_q[0] != $past(ctr_q[0]) || ctr_q[1] != $past(ctr_q[1])
      || ctr_q[2] != $past(ctr_q[2]))
    else $error("counters did not advance on an accepted element");

endmodule

// ===== rtl/tfag_addr_pipe.sv =====
// coordinate, product and sum stages ending in the output register
module tfag_addr_pipe (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     acc_i,
  input  logic                                     adv_i,
  input  tfag_pkg::coord_t [tfag_pkg::MaxRank-1:0] coord_i,
  input  logic                                     last_i,
  input  tfag_pkg::data_t                          value_i,
  input  tfag_pkg::cfg_t                           cfg_i,
  output logic                                     out_valid_o,
  output tfag_pkg::stride_t                        addr_o,
  output tfag_pkg::data_t                          value_o,
  output logic                                     last_o
);

  logic a_vld_q, b_vld_q, c_vld_q;
  tfag_pkg::coord_t  a_coord_q [tfag_pkg::MaxRank];
  tfag_pkg::data_t   a_val_q, b_val_q, c_val_q;
  logic              a_last_q, b_last_q, c_last_q;
  tfag_pkg::stride_t b_prod_q [tfag_pkg::MaxRank];
  tfag_pkg::stride_t c_addr_q;
  tfag_pkg::stride_t sum_d;

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < tfag_pkg::MaxRank; k++) begin
      sum_d = sum_d + b_prod_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= acc_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < tfag_pkg::MaxRank; k++) begin
        a_coord_q[k] <= coord_i[k];
        b_prod_q[k]  <= tfag_pkg::AddrW'(a_coord_q[k]) * cfg_i.stride[k];
      end
      a_val_q  <= value_i;
      a_last_q <= last_i;
      b_val_q  <= a_val_q;
      b_last_q <= a_last_q;
      c_addr_q <= sum_d;
      c_val_q  <= b_val_q;
      c_last_q <= b_last_q;
    end
  end

  assign out_valid_o = c_vld_q;
  assign addr_o      = c_addr_q;
  assign value_o     = c_val_q;
  assign last_o      = c_last_q;

  a_bubble_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && b_vld_q |=> c_vld_q)
    else $error("a beat was lost between the product and output stages");

endmodule

// ===== rtl/tensor_flip_address_generator.sv =====
// top level of the tensor flip address generator
//
// elements of a row-major tensor of up to four dimensions enter on the input
// channel in source order, one beat each (in_valid_i / in_stall_o). for every
// beat one result leaves on the output channel (out_valid_o / out_stall_i):
// the flipped destination address, the element unchanged, and a flag on the
// final element of the tensor, after which the counters are back at zero.
// the result passes the three register stages (coordinates, products,
// address sum) before out_valid_o rises. a beat can be accepted on every
// cycle while neither the receiver nor the stride sequencer holds the input,
// as the counters update on each accepted beat.
// while the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o is raised; nothing is dropped.
// sizes and the flip mask are written on the cfg channel, which is always
// ready. a write starts the stride sequencer, one multiply per cycle for each
// stride above the innermost, and the input is stalled until it finishes.
// reset clears the counters, sets all sizes to one, the flip mask to zero and
// empties the pipeline.
module tensor_flip_address_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tfag_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tfag_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [31:0]                     element_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [31:0]                     dest_address_o,
  output logic [31:0]                     element_out_o,
  output logic                            last_element_o
);

  tfag_pkg::cfg_t cfg;
  tfag_pkg::coord_t [tfag_pkg::MaxRank-1:0] coord;
  logic last;
  logic adv;
  logic acc;

  assign cfg_ready_o = 1'b1;
  assign adv         = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !adv || cfg.busy;
  assign acc         = in_valid_i && !in_stall_o;

  tfag_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tfag_coord_ctr u_ctr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .cfg_i   (cfg),
    .coord_o (coord),
    .last_o  (last)
  );

  tfag_addr_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .adv_i       (adv),
    .coord_i     (coord),
    .last_i      (last),
    .value_i     (element_value_i),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .addr_o      (dest_address_o),
    .value_o     (element_out_o),
    .last_o      (last_element_o)
  );

endmodule

// ===== sim/tb_tensor_flip_address_generator.sv =====
// testbench of the tensor flip address generator with a self-checking scoreboard
`timescale 1ns / 1ps

module tb_tensor_flip_address_generator;

  localparam int unsigned SizeCap       = 1 << tfag_pkg::DimBits;
  localparam int unsigned RandomBeats   = 1600;
  localparam int unsigned WatchdogLimit = 2000;
  localparam logic [tfag_pkg::CfgIdxW-1:0] RegLastIdx = '1;

  typedef struct {
    logic [31:0] addr;
    logic [31:0] value;
    logic        last;
  } flip_result_t;

  // tracks sizes, mask and coordinates, and holds the destination beats still owed
  class flip_scoreboard;
    logic [tfag_pkg::CfgDataW-1:0] size_reg[tfag_pkg::MaxRank];
    logic [tfag_pkg::MaxRank-1:0]  flip_reg;
    int unsigned                   coord[tfag_pkg::MaxRank];
    flip_result_t                  owed_q[$];
    int                            errors;

    function new();
      foreach (size_reg[k]) begin
        size_reg[k] = tfag_pkg::CfgDataW'(1);
        coord[k]    = 0;
      end
      flip_reg = '0;
      errors   = 0;
    endfunction

    function int unsigned extent(int k);
      int unsigned s;
      s = 32'(size_reg[k]);
      if (s == 0) begin
        s = 1;
      end else if (s > SizeCap) begin
        s = SizeCap;
      end
      return s;
    endfunction

    function void write_reg(logic [tfag_pkg::CfgIdxW-1:0] idx,
                            logic [tfag_pkg::CfgDataW-1:0] data);
      if (idx < tfag_pkg::RegFlipMask) begin
        size_reg[idx[tfag_pkg::RankW-1:0]] = data;
      end else if (idx == tfag_pkg::RegFlipMask) begin
        flip_reg = data[tfag_pkg::MaxRank-1:0];
      end
    endfunction

    function longint unsigned tensor_volume();
      longint unsigned v;
      v = 1;
      for (int k = 0; k < tfag_pkg::MaxRank; k++) begin
        v *= 64'(extent(k));
      end
      return v;
    endfunction

    function void note_element(logic [31:0] v);
      flip_result_t    r;
      longint unsigned addr;
      longint unsigned stride;
      int unsigned     s;
      int unsigned     c;
      addr   = 0;
      stride = 1;
      r.last = 1'b1;
      // innermost dimension first, strides grow outward
      for (int k = tfag_pkg::MaxRank - 1; k >= 0; k--) begin
        s = extent(k);
        c = coord[k] & (SizeCap - 1);
        if (c >= s - 1) begin
          c = s - 1;
        end else begin
          r.last = 1'b0;
        end
        if (flip_reg[k]) begin
          c = s - 1 - c;
        end
        addr   += longint'(c) * stride;
        stride *= 64'(s);
      end
      r.addr  = addr[31:0];
      r.value = v;
      owed_q.insert(owed_q.size(), r);
      // advance with carry; a counter left beyond a shrunken size wraps
      for (int k = tfag_pkg::MaxRank - 1; k >= 0; k--) begin
        s = extent(k);
        c = coord[k] & (SizeCap - 1);
        if (c >= s - 1) begin
          coord[k] = 0;
        end else begin
          coord[k] = c + 1;
          break;
        end
      end
    endfunction

    function void check_result(logic [31:0] addr, logic [31:0] value, logic last);
      flip_result_t r;
      if (owed_q.size() == 0) begin
        $error("result beat with nothing owed: dest_address %h", addr);
        errors++;
        return;
      end
      r = owed_q.pop_front();
      if (addr !== r.addr) begin
        $error("dest_address: expected %h, got %h", r.addr, addr);
        errors++;
      end
      if (value !== r.value) begin
        $error("element_out: expected %h, got %h", r.value, value);
        errors++;
      end
      if (last !== r.last) begin
        $error("last_element: expected %b, got %b", r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [tfag_pkg::CfgIdxW-1:0]    cfg_index_i = '0;
  logic [tfag_pkg::CfgDataW-1:0]   cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_stall_o;
  logic [31:0]                     element_value_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic [31:0]                     dest_address_o;
  logic [31:0]                     element_out_o;
  logic                            last_element_o;

  flip_scoreboard sb;
  int unsigned    idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    quiet_cycles = 0;

  tensor_flip_address_generator u_top (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .element_value_i,
    .out_valid_o,
    .out_stall_i,
    .dest_address_o,
    .element_out_o,
    .last_element_o
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // both channels are sampled here, input beat noted before any result is checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_element(element_value_i);
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(dest_address_o, element_out_o, last_element_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL tensor_flip_address_generator");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // raises valid and holds until the write is taken; caller lowers valid
  task automatic cfg_write(logic [tfag_pkg::CfgIdxW-1:0] idx,
                           logic [tfag_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  task automatic push_config(logic [tfag_pkg::CfgDataW-1:0] s0,
                             logic [tfag_pkg::CfgDataW-1:0] s1,
                             logic [tfag_pkg::CfgDataW-1:0] s2,
                             logic [tfag_pkg::CfgDataW-1:0] s3,
                             logic [tfag_pkg::CfgDataW-1:0] mask);
    cfg_write(tfag_pkg::RegSizeDim0,                             s0);
    cfg_write(tfag_pkg::RegSizeDim0 + tfag_pkg::CfgIdxW'(1),     s1);
    cfg_write(tfag_pkg::RegSizeDim0 + tfag_pkg::CfgIdxW'(2),     s2);
    cfg_write(tfag_pkg::RegSizeDim0 + tfag_pkg::CfgIdxW'(3),     s3);
    cfg_write(tfag_pkg::RegFlipMask,                             mask);
    cfg_valid_i <= 1'b0;
  endtask

  // valid stays high after the beat so back-to-back beats never toggle it
  task automatic send_element(logic [31:0] v);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= v;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.owed_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [tfag_pkg::CfgDataW-1:0] sz[tfag_pkg::MaxRank];
    longint unsigned               vol;
    int unsigned                   sent;
    int unsigned                   phase_no;
    int unsigned                   beats;
    int unsigned                   pick;

    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes: every beat is the whole tensor
    send_element(32'h0000_0000);
    send_element(32'hFFFF_FFFF);
    drain_results();

    // zero size, oversized dimension and a mask with upper data bits set
    push_config(9'd0, 9'd1, 9'h1FF, 9'd2, 9'h1F5);
    send_element(32'hA5A5_5A5A);
    send_element(32'h5A5A_A5A5);
    send_element(32'h0F0F_F0F0);
    drain_results();

    // unmapped indexes are ignored
    for (int i = tfag_pkg::RegFlipMask + 1; i <= RegLastIdx; i++) begin
      cfg_write(tfag_pkg::CfgIdxW'(i), 9'h1FF);
    end
    cfg_valid_i <= 1'b0;

    // largest tensor, all mirrored: addresses near the top of the range
    push_config(9'd256, 9'd256, 9'd256, 9'd256, 9'h00F);
    send_element(32'h8000_0001);
    send_element(32'h7FFF_FFFE);
    drain_results();

    // shrinking sizes leaves counters past their extent
    push_config(9'd2, 9'd2, 9'd2, 9'd2, 9'($urandom_range(0, 15)));
    for (int i = 0; i < 16; i++) begin
      send_element($urandom());
    end
    drain_results();

    sent     = 0;
    phase_no = 0;
    while (sent < RandomBeats) begin
      case (phase_no % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      foreach (sz[k]) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          sz[k] = '0;
        end else if (pick == 1) begin
          sz[k] = tfag_pkg::CfgDataW'($urandom_range(257, 511));
        end else if (pick == 2) begin
          sz[k] = tfag_pkg::CfgDataW'($urandom_range(5, 256));
        end else begin
          sz[k] = tfag_pkg::CfgDataW'($urandom_range(1, 4));
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(tfag_pkg::CfgIdxW'($urandom_range(tfag_pkg::RegFlipMask + 1, RegLastIdx)),
                  tfag_pkg::CfgDataW'($urandom()));
      end
      push_config(sz[0], sz[1], sz[2], sz[3], tfag_pkg::CfgDataW'($urandom()));
      vol = sb.tensor_volume();
      if (vol <= 128) begin
        beats = int'(vol) * $urandom_range(1, 3);
      end else begin
        beats = $urandom_range(20, 80);
      end
      for (int i = 0; i < beats; i++) begin
        // hold the sender off until every owed result is back
        if (phase_no % 5 == 2 && i == beats / 2) begin
          drain_results();
        end
        send_element($urandom());
      end
      sent += beats;
      drain_results();
      phase_no++;
    end

    if (sb.errors == 0) begin
      $display("PASS tensor_flip_address_generator");
    end else begin
      $display("FAIL tensor_flip_address_generator");
    end
    $finish;
  end

endmodule
